// ----- rtl/mrd_pkg.sv -----
// Shared types and constants of the Modbus RTU response deframer.
`timescale 1ns / 1ps
`default_nettype none

package mrd_pkg;

    // Register indexes on the configuration channel
    localparam logic [2:0] REG_SLAVE_ADDRESS       = 3'd0;
    localparam logic [2:0] REG_READ_FUNCTION_CODE  = 3'd1;
    localparam logic [2:0] REG_WRITE_FUNCTION_CODE = 3'd2;
    localparam logic [2:0] REG_EXPECTED_REGISTER   = 3'd3;

    // Result kinds
    localparam logic [1:0] KIND_READ_DATA = 2'd0;
    localparam logic [1:0] KIND_WRITE_ACK = 2'd1;
    localparam logic [1:0] KIND_WRITE_NAK = 2'd2;

    localparam logic [15:0] CRC_INIT = 16'hFFFF;
    localparam logic [15:0] CRC_POLY = 16'hA001;
    localparam int unsigned FRAME_OVERHEAD = 5;
    localparam int unsigned READ_STORE_BYTES = 6;
    localparam int unsigned WRITE_BODY_BYTES = 4;

    typedef struct packed {
        logic [7:0]  slave_address;
        logic [7:0]  read_function_code;
        logic [7:0]  write_function_code;
        logic [15:0] expected_register;
    } cfg_t;

    typedef struct packed {
        logic [1:0]  result_kind;
        logic [15:0] first_word;
        logic [15:0] second_word;
        logic [15:0] third_word;
        logic [15:0] echoed_register;
    } result_t;

endpackage

`default_nettype wire

// ----- rtl/mrd_crc16.sv -----
// Byte-wide CRC-16/Modbus update, eight reflected shift steps unrolled.
`timescale 1ns / 1ps
`default_nettype none

module mrd_crc16
(
    input  wire logic [15:0] crc_in,
    input  wire logic [7:0]  data,
    output logic      [15:0] crc_out
);
    import mrd_pkg::*;

    always_comb
    begin
        logic [15:0] c;
        c = crc_in ^ {8'h00, data};
        for (int k = 0; k < 8; k++)
        begin
            if (c[0])
            begin
                c = (c >> 1) ^ CRC_POLY;
            end
            else
            begin
                c = c >> 1;
            end
        end
        crc_out = c;
    end

endmodule

`default_nettype wire

// ----- rtl/mrd_parser.sv -----
// Frame hunting state machine, running CRC and field capture.
`timescale 1ns / 1ps
`default_nettype none

module mrd_parser
#(
    parameter int unsigned MAX_FRAME_BYTES = 64
)
(
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire mrd_pkg::cfg_t   cfg,
    input  wire logic            step,
    input  wire logic [7:0]      rx_byte,
    output logic                 res_valid,
    output mrd_pkg::result_t     res
);
    import mrd_pkg::*;

    localparam logic [9:0] MAX_BYTES = 10'(MAX_FRAME_BYTES);
    localparam logic [9:0] OVERHEAD  = 10'(FRAME_OVERHEAD);
    localparam logic [7:0] STORE_LIM = 8'(READ_STORE_BYTES);
    localparam logic [7:0] BODY_LIM  = 8'(WRITE_BODY_BYTES);

    typedef enum logic [2:0] {
        PH_ADDR  = 3'd0,
        PH_FUNC  = 3'd1,
        PH_COUNT = 3'd2,
        PH_DATA  = 3'd3,
        PH_BODY  = 3'd4,
        PH_CRCLO = 3'd5,
        PH_CRCHI = 3'd6
    } phase_t;

    phase_t      phase_reg, phase_next;
    logic [15:0] crc_reg, crc_next;
    logic [7:0]  pos_reg, pos_next;
    logic [7:0]  count_reg, count_next;
    logic        is_write_reg, is_write_next;
    logic [15:0] word0_reg, word0_next;
    logic [15:0] word1_reg, word1_next;
    logic [15:0] word2_reg, word2_next;
    logic [15:0] wreg_reg, wreg_next;
    logic [15:0] wval_reg, wval_next;
    logic [7:0]  crc_lo_reg, crc_lo_next;

    logic [15:0] crc_src;
    logic [15:0] crc_upd;
    logic        func_known;
    logic        is_addr;
    logic [7:0]  pos_inc;
    logic [15:0] rx_crc;

    assign func_known = (rx_byte == cfg.read_function_code) ||
                        (rx_byte == cfg.write_function_code);
    assign is_addr    = (rx_byte == cfg.slave_address);
    assign pos_inc    = pos_reg + 8'd1;
    assign rx_crc     = {rx_byte, crc_lo_reg};

    // Continue the running CRC inside a frame, restart it on an address byte
    always_comb
    begin
        if ((phase_reg == PH_COUNT) || (phase_reg == PH_DATA) || (phase_reg == PH_BODY) ||
            ((phase_reg == PH_FUNC) && func_known))
        begin
            crc_src = crc_reg;
        end
        else
        begin
            crc_src = CRC_INIT;
        end
    end

    mrd_crc16 u_crc
    (
        .crc_in  (crc_src),
        .data    (rx_byte),
        .crc_out (crc_upd)
    );

    always_comb
    begin
        phase_next    = phase_reg;
        crc_next      = crc_reg;
        pos_next      = pos_reg;
        count_next    = count_reg;
        is_write_next = is_write_reg;
        word0_next    = word0_reg;
        word1_next    = word1_reg;
        word2_next    = word2_reg;
        wreg_next     = wreg_reg;
        wval_next     = wval_reg;
        crc_lo_next   = crc_lo_reg;
        res_valid     = 1'b0;
        res           = '0;

        if (step)
        begin
            unique case (phase_reg)
                PH_FUNC:
                begin
                    if (rx_byte == cfg.read_function_code)
                    begin
                        crc_next      = crc_upd;
                        is_write_next = 1'b0;
                        phase_next    = PH_COUNT;
                    end
                    else if (rx_byte == cfg.write_function_code)
                    begin
                        crc_next      = crc_upd;
                        is_write_next = 1'b1;
                        pos_next      = 8'd0;
                        phase_next    = PH_BODY;
                    end
                    else if (is_addr)
                    begin
                        // Unknown function: recheck this byte as a fresh address
                        crc_next      = crc_upd;
                        pos_next      = 8'd0;
                        count_next    = 8'd0;
                        is_write_next = 1'b0;
                        word0_next    = '0;
                        word1_next    = '0;
                        word2_next    = '0;
                        wreg_next     = '0;
                        wval_next     = '0;
                        phase_next    = PH_FUNC;
                    end
                    else
                    begin
                        phase_next = PH_ADDR;
                    end
                end
                PH_COUNT:
                begin
                    if (({2'b00, rx_byte} + OVERHEAD) > MAX_BYTES)
                    begin
                        phase_next = PH_ADDR;
                    end
                    else
                    begin
                        crc_next   = crc_upd;
                        count_next = rx_byte;
                        pos_next   = 8'd0;
                        phase_next = (rx_byte == 8'd0) ? PH_CRCLO : PH_DATA;
                    end
                end
                PH_DATA:
                begin
                    crc_next = crc_upd;
                    if (pos_reg < STORE_LIM)
                    begin
                        unique case (pos_reg[2:0])
                            3'd0:    word0_next = {rx_byte, word0_reg[7:0]};
                            3'd1:    word0_next = {word0_reg[15:8], rx_byte};
                            3'd2:    word1_next = {rx_byte, word1_reg[7:0]};
                            3'd3:    word1_next = {word1_reg[15:8], rx_byte};
                            3'd4:    word2_next = {rx_byte, word2_reg[7:0]};
                            3'd5:    word2_next = {word2_reg[15:8], rx_byte};
                            default: word2_next = word2_reg;
                        endcase
                    end
                    pos_next = pos_inc;
                    if (pos_inc >= count_reg)
                    begin
                        phase_next = PH_CRCLO;
                    end
                end
                PH_BODY:
                begin
                    crc_next = crc_upd;
                    unique case (pos_reg[1:0])
                        2'd0:    wreg_next = {rx_byte, wreg_reg[7:0]};
                        2'd1:    wreg_next = {wreg_reg[15:8], rx_byte};
                        2'd2:    wval_next = {rx_byte, wval_reg[7:0]};
                        default: wval_next = {wval_reg[15:8], rx_byte};
                    endcase
                    pos_next = pos_inc;
                    if (pos_inc >= BODY_LIM)
                    begin
                        phase_next = PH_CRCLO;
                    end
                end
                PH_CRCLO:
                begin
                    crc_lo_next = rx_byte;
                    phase_next  = PH_CRCHI;
                end
                PH_CRCHI:
                begin
                    phase_next = PH_ADDR;
                    if (rx_crc == crc_reg)
                    begin
                        res_valid = 1'b1;
                        if (is_write_reg)
                        begin
                            res.result_kind     = ((wreg_reg == cfg.expected_register) &&
                                                   (wval_reg != 16'd0)) ?
                                                  KIND_WRITE_ACK : KIND_WRITE_NAK;
                            res.echoed_register = wreg_reg;
                        end
                        else
                        begin
                            res.result_kind = KIND_READ_DATA;
                            res.first_word  = word0_reg;
                            res.second_word = word1_reg;
                            res.third_word  = word2_reg;
                        end
                    end
                end
                default:
                begin
                    // Hunt for the address byte
                    if (is_addr)
                    begin
                        crc_next      = crc_upd;
                        pos_next      = 8'd0;
                        count_next    = 8'd0;
                        is_write_next = 1'b0;
                        word0_next    = '0;
                        word1_next    = '0;
                        word2_next    = '0;
                        wreg_next     = '0;
                        wval_next     = '0;
                        phase_next    = PH_FUNC;
                    end
                    else
                    begin
                        phase_next = PH_ADDR;
                    end
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg    <= PH_ADDR;
            crc_reg      <= CRC_INIT;
            pos_reg      <= '0;
            count_reg    <= '0;
            is_write_reg <= 1'b0;
            word0_reg    <= '0;
            word1_reg    <= '0;
            word2_reg    <= '0;
            wreg_reg     <= '0;
            wval_reg     <= '0;
            crc_lo_reg   <= '0;
        end
        else
        begin
            phase_reg    <= phase_next;
            crc_reg      <= crc_next;
            pos_reg      <= pos_next;
            count_reg    <= count_next;
            is_write_reg <= is_write_next;
            word0_reg    <= word0_next;
            word1_reg    <= word1_next;
            word2_reg    <= word2_next;
            wreg_reg     <= wreg_next;
            wval_reg     <= wval_next;
            crc_lo_reg   <= crc_lo_next;
        end
    end

    a_res_only_at_crc_high: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid |-> (step && (phase_reg == PH_CRCHI)))
        else $error("result raised outside the CRC high byte");

    a_back_to_hunt: assert property (@(posedge clk) disable iff (!rst_n)
        (step && (phase_reg == PH_CRCHI)) |=> (phase_reg == PH_ADDR))
        else $error("frame end did not return to address hunt");

    a_read_result_clean: assert property (@(posedge clk) disable iff (!rst_n)
        (res_valid && (res.result_kind == KIND_READ_DATA)) |-> (res.echoed_register == 16'd0))
        else $error("read result carries an echoed register");

endmodule

`default_nettype wire

// ----- rtl/mrd_out_reg.sv -----
// Result register that holds a finished word until the sink takes it.
`timescale 1ns / 1ps
`default_nettype none

module mrd_out_reg
(
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             load,
    input  wire mrd_pkg::result_t res,
    output logic                  full,
    input  wire logic             take,
    output mrd_pkg::result_t      res_out
);
    import mrd_pkg::*;

    logic    full_reg, full_next;
    result_t data_reg;

    always_comb
    begin
        if (load)
        begin
            full_next = 1'b1;
        end
        else if (take)
        begin
            full_next = 1'b0;
        end
        else
        begin
            full_next = full_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            full_reg <= 1'b0;
        end
        else
        begin
            full_reg <= full_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            data_reg <= res;
        end
    end

    assign full    = full_reg;
    assign res_out = data_reg;

    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        !(load && full_reg && !take))
        else $error("held result overwritten before it was taken");

endmodule

`default_nettype wire

// ----- rtl/modbus_rtu_response_deframer.sv -----
// Top level: Modbus RTU response deframer with CRC-16/Modbus check.
// A result word appears on m_tvalid in the cycle after its CRC high byte is taken.
// Throughput: one received byte per cycle while the result register is empty or draining.
// s_tready drops only while a result waits and m_tready is low.
// Reset (rst_n low, asynchronous) restores register defaults and the address hunt.
`timescale 1ns / 1ps
`default_nettype none

module modbus_rtu_response_deframer
#(
    parameter int unsigned MAX_FRAME_BYTES = 64
)
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    // configuration write channel
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic [2:0]  cfg_index,
    input  wire logic [15:0] cfg_data,
    // received bytes
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [7:0]  s_tdata,   // [7:0] rx_byte
    // results
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [63:0]      m_tdata,   // [15:0] first_word, [31:16] second_word,
                                        // [47:32] third_word, [63:48] echoed_register
    output logic [1:0]       m_tuser    // [1:0] result_kind
);
    import mrd_pkg::*;

    cfg_t    cfg_reg, cfg_next;
    logic    step;
    logic    res_valid;
    result_t res;
    result_t res_held;
    logic    full;

    assign cfg_ready = 1'b1;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_valid)
        begin
            unique case (cfg_index)
                REG_SLAVE_ADDRESS:       cfg_next.slave_address       = cfg_data[7:0];
                REG_READ_FUNCTION_CODE:  cfg_next.read_function_code  = cfg_data[7:0];
                REG_WRITE_FUNCTION_CODE: cfg_next.write_function_code = cfg_data[7:0];
                REG_EXPECTED_REGISTER:   cfg_next.expected_register   = cfg_data;
                default:                 cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.slave_address       <= 8'd1;
            cfg_reg.read_function_code  <= 8'd3;
            cfg_reg.write_function_code <= 8'd6;
            cfg_reg.expected_register   <= 16'd0;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign s_tready = !full || m_tready;
    assign step     = s_tvalid && s_tready;

    mrd_parser #(
        .MAX_FRAME_BYTES (MAX_FRAME_BYTES)
    ) u_parser
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg_reg),
        .step      (step),
        .rx_byte   (s_tdata),
        .res_valid (res_valid),
        .res       (res)
    );

    mrd_out_reg u_out
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .load    (res_valid),
        .res     (res),
        .full    (full),
        .take    (m_tready),
        .res_out (res_held)
    );

    assign m_tvalid = full;
    assign m_tdata  = {res_held.echoed_register, res_held.third_word,
                       res_held.second_word, res_held.first_word};
    assign m_tuser  = res_held.result_kind;

endmodule

`default_nettype wire

// ----- dv/modbus_rtu_response_deframer_tb.sv -----
// Self-checking testbench for the Modbus RTU response deframer.
`timescale 1ns / 1ps

module modbus_rtu_response_deframer_tb;
    import mrd_pkg::*;

    localparam int unsigned FRAME_LIMIT   = 64;
    localparam int unsigned HOLD_CYCLES   = 300;
    localparam int unsigned SETTLE_CYCLES = 4;
    localparam int unsigned DRAIN_LIMIT   = 20000;

    localparam logic [7:0] DEFAULT_SLAVE_ADDRESS = 8'h01;
    localparam logic [7:0] DEFAULT_READ_CODE     = 8'h03;
    localparam logic [7:0] DEFAULT_WRITE_CODE    = 8'h06;

    class modbus_response_checker #(parameter int unsigned FRAME_LIMIT = 64);
        typedef enum logic [2:0]
        {
            HUNT_ADDR,
            HUNT_FUNC,
            HUNT_COUNT,
            HUNT_DATA,
            HUNT_BODY,
            HUNT_CRC_LO,
            HUNT_CRC_HI
        } hunt_e;

        cfg_t        regs;
        hunt_e       phase;
        logic [15:0] crc_acc;
        logic [7:0]  data_index;
        logic [7:0]  data_len;
        logic        write_echo;
        logic [15:0] read_words[3];
        logic [15:0] echo_reg;
        logic [15:0] echo_value;
        logic [7:0]  crc_low_byte;
        result_t     awaited_responses[$];
        int          failures;

        function new();
            regs.slave_address       = DEFAULT_SLAVE_ADDRESS;
            regs.read_function_code  = DEFAULT_READ_CODE;
            regs.write_function_code = DEFAULT_WRITE_CODE;
            regs.expected_register   = '0;
            phase        = HUNT_ADDR;
            crc_acc      = CRC_INIT;
            data_index   = '0;
            data_len     = '0;
            write_echo   = 1'b0;
            read_words   = '{default: '0};
            echo_reg     = '0;
            echo_value   = '0;
            crc_low_byte = '0;
            failures     = 0;
        endfunction

        static function logic [15:0] crc16_update(logic [15:0] crc, logic [7:0] rx);
            logic [15:0] acc;
            acc = crc ^ {8'h00, rx};
            for (int k = 0; k < 8; k++)
                acc = acc[0] ? ((acc >> 1) ^ CRC_POLY) : (acc >> 1);
            return acc;
        endfunction

        function void write_register(logic [2:0] index, logic [15:0] value);
            case (index)
                REG_SLAVE_ADDRESS:       regs.slave_address       = value[7:0];
                REG_READ_FUNCTION_CODE:  regs.read_function_code  = value[7:0];
                REG_WRITE_FUNCTION_CODE: regs.write_function_code = value[7:0];
                REG_EXPECTED_REGISTER:   regs.expected_register   = value;
                default: ;
            endcase
        endfunction

        // Open a frame on a matching address, otherwise keep hunting
        function void open_or_hunt(logic [7:0] rx);
            if (rx == regs.slave_address)
            begin
                crc_acc    = crc16_update(CRC_INIT, rx);
                data_index = '0;
                data_len   = '0;
                write_echo = 1'b0;
                read_words = '{default: '0};
                echo_reg   = '0;
                echo_value = '0;
                phase      = HUNT_FUNC;
            end
            else
                phase = HUNT_ADDR;
        endfunction

        function void take_rx_byte(logic [7:0] rx);
            result_t want;
            case (phase)
                HUNT_FUNC:
                begin
                    // read wins when both codes match
                    if (rx == regs.read_function_code)
                    begin
                        crc_acc    = crc16_update(crc_acc, rx);
                        write_echo = 1'b0;
                        phase      = HUNT_COUNT;
                    end
                    else if (rx == regs.write_function_code)
                    begin
                        crc_acc    = crc16_update(crc_acc, rx);
                        write_echo = 1'b1;
                        data_index = '0;
                        phase      = HUNT_BODY;
                    end
                    else
                        open_or_hunt(rx);
                end
                HUNT_COUNT:
                begin
                    if (int'(rx) + FRAME_OVERHEAD > FRAME_LIMIT)
                        phase = HUNT_ADDR;
                    else
                    begin
                        crc_acc    = crc16_update(crc_acc, rx);
                        data_len   = rx;
                        data_index = '0;
                        phase      = (rx == 8'h00) ? HUNT_CRC_LO : HUNT_DATA;
                    end
                end
                HUNT_DATA:
                begin
                    crc_acc = crc16_update(crc_acc, rx);
                    if (data_index < READ_STORE_BYTES)
                    begin
                        if (data_index[0])
                            read_words[data_index >> 1][7:0] = rx;
                        else
                            read_words[data_index >> 1][15:8] = rx;
                    end
                    data_index = data_index + 8'd1;
                    if (data_index >= data_len)
                        phase = HUNT_CRC_LO;
                end
                HUNT_BODY:
                begin
                    crc_acc = crc16_update(crc_acc, rx);
                    case (data_index[1:0])
                        2'd0: echo_reg[15:8]   = rx;
                        2'd1: echo_reg[7:0]    = rx;
                        2'd2: echo_value[15:8] = rx;
                        default: echo_value[7:0] = rx;
                    endcase
                    data_index = data_index + 8'd1;
                    if (data_index >= WRITE_BODY_BYTES)
                        phase = HUNT_CRC_LO;
                end
                HUNT_CRC_LO:
                begin
                    crc_low_byte = rx;
                    phase        = HUNT_CRC_HI;
                end
                HUNT_CRC_HI:
                begin
                    phase = HUNT_ADDR;
                    // drop the frame silently on a CRC mismatch
                    if ({rx, crc_low_byte} == crc_acc)
                    begin
                        want = '0;
                        if (write_echo)
                        begin
                            want.result_kind =
                                (echo_reg == regs.expected_register && echo_value != 16'h0000)
                                ? KIND_WRITE_ACK : KIND_WRITE_NAK;
                            want.echoed_register = echo_reg;
                        end
                        else
                        begin
                            want.result_kind = KIND_READ_DATA;
                            want.first_word  = read_words[0];
                            want.second_word = read_words[1];
                            want.third_word  = read_words[2];
                        end
                        awaited_responses.push_back(want);
                    end
                end
                default: open_or_hunt(rx);
            endcase
        endfunction

        function void compare_field(string name, logic [15:0] want, logic [15:0] got);
            if (want !== got)
            begin
                $error("%s: expected %h, actual %h", name, want, got);
                failures++;
            end
        endfunction

        function void check_response(logic [1:0] kind, logic [63:0] data);
            result_t want;
            if (awaited_responses.size() == 0)
            begin
                $error("unexpected response word: kind %0d data %h", kind, data);
                failures++;
                return;
            end
            want = awaited_responses.pop_front();
            compare_field("result_kind", 16'(want.result_kind), 16'(kind));
            compare_field("first_word", want.first_word, data[15:0]);
            compare_field("second_word", want.second_word, data[31:16]);
            compare_field("third_word", want.third_word, data[47:32]);
            compare_field("echoed_register", want.echoed_register, data[63:48]);
        endfunction
    endclass

    typedef modbus_response_checker #(FRAME_LIMIT) checker_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [2:0]  cfg_index = '0;
    logic [15:0] cfg_data = '0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [7:0]  s_tdata = '0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [63:0] m_tdata;
    logic [1:0]  m_tuser;

    checker_t   chk;
    logic [7:0] frame_q[$];
    int         frame_bytes = 0;
    int         tx_calm = 0;
    int         rx_calm = 0;
    logic       hold_request = 1'b0;

    modbus_rtu_response_deframer
    #(
        .MAX_FRAME_BYTES(FRAME_LIMIT)
    )
    u_top
    (
        .clk(clk),
        .rst_n(rst_n),
        .cfg_valid(cfg_valid),
        .cfg_ready(cfg_ready),
        .cfg_index(cfg_index),
        .cfg_data(cfg_data),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata(s_tdata),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata(m_tdata),
        .m_tuser(m_tuser)
    );

    always #1 clk = ~clk;

    // Mostly short gaps, a few long ones, and now and then a calm stretch with none
    function automatic int pick_gap(inout int calm);
        int r;
        if (calm > 0)
        begin
            calm--;
            return 0;
        end
        r = $urandom_range(0, 99);
        if (r < 2)
        begin
            calm = $urandom_range(30, 120);
            return 0;
        end
        if (r < 55)
            return 0;
        if (r < 85)
            return $urandom_range(1, 3);
        if (r < 97)
            return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    function automatic int pick_count();
        int r;
        r = $urandom_range(0, 99);
        if (r < 70)
            return $urandom_range(0, READ_STORE_BYTES);
        if (r < 90)
            return $urandom_range(READ_STORE_BYTES + 1, 12);
        if (r < 96)
            return $urandom_range(13, FRAME_LIMIT - FRAME_OVERHEAD);
        return FRAME_LIMIT - FRAME_OVERHEAD;
    endfunction

    function automatic logic [7:0] data_byte();
        int r;
        r = $urandom_range(0, 9);
        if (r == 0)
            return 8'h00;
        if (r == 1)
            return 8'hFF;
        return 8'($urandom);
    endfunction

    function automatic void add_read_body(int count);
        frame_q.push_back(chk.regs.slave_address);
        frame_q.push_back(chk.regs.read_function_code);
        frame_q.push_back(8'(count));
        repeat (count)
            frame_q.push_back(data_byte());
    endfunction

    function automatic void add_write_body();
        logic [15:0] echo_word;
        logic [15:0] value_word;
        echo_word = $urandom_range(0, 1) ? chk.regs.expected_register : 16'($urandom);
        case ($urandom_range(0, 4))
            0: value_word = 16'h0000;
            1: value_word = 16'hFFFF;
            default: value_word = 16'($urandom);
        endcase
        frame_q.push_back(chk.regs.slave_address);
        frame_q.push_back(chk.regs.write_function_code);
        frame_q.push_back(echo_word[15:8]);
        frame_q.push_back(echo_word[7:0]);
        frame_q.push_back(value_word[15:8]);
        frame_q.push_back(value_word[7:0]);
    endfunction

    // Append the CRC, low byte first; flip one bit of it for a bad frame
    function automatic void seal_frame(bit corrupt);
        logic [15:0] crc;
        crc = CRC_INIT;
        foreach (frame_q[i])
            crc = chk.crc16_update(crc, frame_q[i]);
        if (corrupt)
            crc ^= 16'h0001 << $urandom_range(0, 15);
        frame_q.push_back(crc[7:0]);
        frame_q.push_back(crc[15:8]);
    endfunction

    task automatic send_byte(logic [7:0] value);
        int gap;
        @(negedge clk);
        s_tvalid <= 1'b1;
        s_tdata  <= value;
        do @(posedge clk); while (!s_tready);
        chk.take_rx_byte(value);
        gap = pick_gap(tx_calm);
        if (gap > 0)
        begin
            @(negedge clk);
            s_tvalid <= 1'b0;
            repeat (gap - 1) @(negedge clk);
        end
    endtask

    task automatic send_frame();
        foreach (frame_q[i])
            send_byte(frame_q[i]);
        frame_bytes += frame_q.size();
        frame_q.delete();
    endtask

    task automatic send_random_frame();
        int pick;
        int cut;
        pick = $urandom_range(0, 99);
        if (pick < 35)
        begin
            add_read_body(pick_count());
            seal_frame(1'b0);
        end
        else if (pick < 62)
        begin
            add_write_body();
            seal_frame(1'b0);
        end
        else if (pick < 70)
        begin
            if (pick[0])
                add_read_body(pick_count());
            else
                add_write_body();
            seal_frame(1'b1);
        end
        else if (pick < 76)
        begin
            // count too large for the frame limit, then up to four stray data bytes
            frame_q.push_back(chk.regs.slave_address);
            frame_q.push_back(chk.regs.read_function_code);
            frame_q.push_back(8'($urandom_range(FRAME_LIMIT - FRAME_OVERHEAD + 1, 255)));
            repeat ($urandom_range(0, 4))
                frame_q.push_back(data_byte());
        end
        else if (pick < 84)
        begin
            // stray function byte, rechecked as an address, then a good frame
            frame_q.push_back(chk.regs.slave_address);
            frame_q.push_back((pick < 80) ? chk.regs.slave_address : 8'($urandom));
            send_frame();
            if (pick[0])
                add_read_body(pick_count());
            else
                add_write_body();
            seal_frame(1'b0);
        end
        else if (pick < 92)
        begin
            if (pick[0])
                add_read_body(pick_count());
            else
                add_write_body();
            seal_frame(1'b0);
            cut = $urandom_range(2, frame_q.size() - 1);
            while (frame_q.size() > cut)
                void'(frame_q.pop_back());
        end
        else
        begin
            repeat ($urandom_range(1, 6))
                send_byte(8'($urandom));
            return;
        end
        send_frame();
    endtask

    task automatic random_burst(int count);
        int target;
        target = frame_bytes + count;
        while (frame_bytes < target)
            send_random_frame();
    endtask

    // Hold input and wait for every pending response word
    task automatic settle();
        @(negedge clk);
        s_tvalid <= 1'b0;
        while (chk.awaited_responses.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(logic [2:0] index, logic [15:0] value);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= index;
        cfg_data  <= value;
        do @(posedge clk); while (!cfg_ready);
        chk.write_register(index, value);
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    task automatic configure(logic [7:0] slave, logic [7:0] read_code,
                             logic [7:0] write_code, logic [15:0] expected);
        write_reg(REG_SLAVE_ADDRESS, {8'($urandom), slave});
        write_reg(REG_READ_FUNCTION_CODE, {8'($urandom), read_code});
        write_reg(REG_WRITE_FUNCTION_CODE, {8'($urandom), write_code});
        write_reg(REG_EXPECTED_REGISTER, expected);
    endtask

    always @(posedge clk)
    begin
        if (rst_n && m_tvalid && m_tready)
            chk.check_response(m_tuser, m_tdata);
    end

    initial
    begin : receiver
        int gap;
        wait (rst_n);
        forever
        begin
            @(negedge clk);
            if (hold_request)
            begin
                hold_request = 1'b0;
                m_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(negedge clk);
            end
            else
            begin
                gap = pick_gap(rx_calm);
                m_tready <= (gap == 0);
                if (gap > 1)
                    repeat (gap - 1) @(negedge clk);
            end
        end
    end

    initial
    begin
        #2_000_000;
        $display("CHECKS FAILED");
        $finish;
    end

    initial
    begin
        chk = new();
        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // short read with extreme data, then a write echo with a zero value
        frame_q = {chk.regs.slave_address, chk.regs.read_function_code,
                   8'h03, 8'hFF, 8'h00, 8'hFF};
        seal_frame(1'b0);
        send_frame();
        frame_q = {chk.regs.slave_address, chk.regs.write_function_code,
                   8'h00, 8'h00, 8'h00, 8'h00};
        seal_frame(1'b0);
        send_frame();
        // unknown function byte, then an empty read
        frame_q = {chk.regs.slave_address, chk.regs.write_function_code + 8'h01};
        send_frame();
        frame_q = {chk.regs.slave_address, chk.regs.read_function_code, 8'h00};
        seal_frame(1'b0);
        send_frame();
        // count byte beyond the frame limit
        frame_q = {chk.regs.slave_address, chk.regs.read_function_code, 8'hFF};
        send_frame();

        random_burst(130);
        // stall the result side while complete frames keep arriving
        hold_request = 1'b1;
        repeat (4)
        begin
            add_read_body($urandom_range(0, READ_STORE_BYTES));
            seal_frame(1'b0);
            send_frame();
        end
        random_burst(130);
        settle();

        configure(8'h00, 8'hFF, 8'h00, 16'hFFFF);
        random_burst(120);
        settle();
        random_burst(140);
        settle();

        configure(8'hFF, 8'h00, 8'hFF, 16'h0000);
        random_burst(260);
        settle();

        // out-of-range index must leave every register alone
        write_reg(3'(REG_EXPECTED_REGISTER + $urandom_range(1, 4)), 16'($urandom));
        // equal read and write codes
        begin
            logic [7:0] shared_code;
            shared_code = 8'($urandom);
            configure(8'($urandom), shared_code, shared_code, 16'($urandom));
        end
        random_burst(260);
        settle();

        configure(8'($urandom), 8'($urandom), 8'($urandom), 16'($urandom));
        random_burst(260);

        @(negedge clk);
        s_tvalid <= 1'b0;
        for (int i = 0; i < DRAIN_LIMIT && chk.awaited_responses.size() != 0; i++)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (chk.awaited_responses.size() != 0)
        begin
            $error("%0d response words never arrived", chk.awaited_responses.size());
            chk.failures++;
        end
        if (chk.failures == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule

// ----- filelist.f -----
rtl/mrd_pkg.sv
rtl/mrd_crc16.sv
rtl/mrd_parser.sv
rtl/mrd_out_reg.sv
rtl/modbus_rtu_response_deframer.sv
dv/modbus_rtu_response_deframer_tb.sv
